// File: rtl/swmh_pkg.sv
package swmh_pkg;

    // Block dimensions
    localparam int WINDOW_LENGTH = 16384;
    localparam int NUM_BINS      = 256;
    localparam int SAMPLE_W      = 8;
    localparam int HELD_W        = 15;

    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
    localparam int CNT_W  = FILL_W;
    localparam int STEP_W = 4;

    localparam logic [BIN_W-1:0]    LAST_BIN  = BIN_W'(NUM_BINS - 1);
    localparam logic [SAMPLE_W:0]   BIN_LIMIT = (SAMPLE_W + 1)'(NUM_BINS);
    localparam logic [FILL_W-1:0]   WIN_FULL  = FILL_W'(WINDOW_LENGTH);
    localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(WINDOW_LENGTH - 1);

    // Program steps
    typedef enum logic [STEP_W-1:0] {
        ST_IDLE,
        ST_RD_NEW,
        ST_INC_NEW,
        ST_RD_OLD,
        ST_DEC_OLD,
        ST_WR_RING,
        ST_SCAN_LO,
        ST_DECIDE,
        ST_SCAN_HI,
        ST_EMIT
    } step_t;

    // Sequencing condition of a control word
    typedef enum logic [2:0] {
        C_NEXT,       // advance
        C_ACCEPT,     // hold until a request is taken, then advance
        C_NOT_FULL,   // jump when the window is not yet full, else advance
        C_DONE,       // hold until the scan hits, then jump
        C_RESOLVED,   // jump when the median needs no upper scan, else advance
        C_EMIT        // hold until the output register is free, then jump
    } cond_t;

    // Histogram read address source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_SAMPLE,
        RD_OLD,
        RD_SCAN
    } rd_src_t;

    // Histogram write operation
    typedef enum logic [1:0] {
        WR_NONE,
        WR_INC,
        WR_DEC
    } wr_op_t;

    typedef struct packed {
        logic    take;
        rd_src_t rd_src;
        wr_op_t  wr_op;
        logic    ring_rd;
        logic    ring_wr;
        logic    scan_lo;
        logic    scan_hi;
        logic    decide;
        logic    emit;
        cond_t   cond;
        step_t   tgt;
    } uword_t;

    typedef struct packed {
        logic full;
        logic done;
        logic resolved;
    } dp_stat_t;

    typedef struct packed {
        logic     accept;
        logic     out_free;
        dp_stat_t dp;
    } seq_flags_t;

    function automatic uword_t uw(input logic take, input rd_src_t rd_src,
                                  input wr_op_t wr_op, input logic ring_rd,
                                  input logic ring_wr, input logic scan_lo,
                                  input logic scan_hi, input logic decide,
                                  input logic emit, input cond_t cond,
                                  input step_t tgt);
        uword_t w;
        w.take    = take;
        w.rd_src  = rd_src;
        w.wr_op   = wr_op;
        w.ring_rd = ring_rd;
        w.ring_wr = ring_wr;
        w.scan_lo = scan_lo;
        w.scan_hi = scan_hi;
        w.decide  = decide;
        w.emit    = emit;
        w.cond    = cond;
        w.tgt     = tgt;
        return w;
    endfunction

    // Control store
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        unique case (step)
            ST_IDLE:    w = uw(1'b1, RD_NONE,   WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, C_ACCEPT,   ST_IDLE);
            ST_RD_NEW:  w = uw(1'b0, RD_SAMPLE, WR_NONE, 1'b1, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, C_NEXT,     ST_IDLE);
            ST_INC_NEW: w = uw(1'b0, RD_NONE,   WR_INC,  1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, C_NOT_FULL, ST_WR_RING);
            ST_RD_OLD:  w = uw(1'b0, RD_OLD,    WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, C_NEXT,     ST_IDLE);
            ST_DEC_OLD: w = uw(1'b0, RD_NONE,   WR_DEC,  1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, C_NEXT,     ST_IDLE);
            ST_WR_RING: w = uw(1'b0, RD_NONE,   WR_NONE, 1'b0, 1'b1, 1'b0, 1'b0,
                               1'b0, 1'b0, C_NEXT,     ST_IDLE);
            ST_SCAN_LO: w = uw(1'b0, RD_SCAN,   WR_NONE, 1'b0, 1'b0, 1'b1, 1'b0,
                               1'b0, 1'b0, C_DONE,     ST_DECIDE);
            ST_DECIDE:  w = uw(1'b0, RD_NONE,   WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b1, 1'b0, C_RESOLVED, ST_EMIT);
            ST_SCAN_HI: w = uw(1'b0, RD_SCAN,   WR_NONE, 1'b0, 1'b0, 1'b0, 1'b1,
                               1'b0, 1'b0, C_DONE,     ST_EMIT);
            ST_EMIT:    w = uw(1'b0, RD_NONE,   WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b1, C_EMIT,     ST_IDLE);
            default:    w = uw(1'b0, RD_NONE,   WR_NONE, 1'b0, 1'b0, 1'b0, 1'b0,
                               1'b0, 1'b0, C_EMIT,     ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

// File: rtl/swmh_seq.sv
module swmh_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swmh_pkg::seq_flags_t  flags,
    output swmh_pkg::uword_t      uword
);

    swmh_pkg::step_t step_reg;
    swmh_pkg::step_t step_next;
    swmh_pkg::step_t step_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= swmh_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        uword     = swmh_pkg::ucode(step_reg);
        step_inc  = swmh_pkg::step_t'(step_reg + 4'd1);
        step_next = step_reg;
        unique case (uword.cond)
            swmh_pkg::C_NEXT: begin
                step_next = step_inc;
            end
            swmh_pkg::C_ACCEPT: begin
                if (flags.accept) step_next = step_inc;
            end
            swmh_pkg::C_NOT_FULL: begin
                step_next = flags.dp.full ? step_inc : uword.tgt;
            end
            swmh_pkg::C_DONE: begin
                if (flags.dp.done) step_next = uword.tgt;
            end
            swmh_pkg::C_RESOLVED: begin
                step_next = flags.dp.resolved ? uword.tgt : step_inc;
            end
            swmh_pkg::C_EMIT: begin
                if (flags.out_free) step_next = uword.tgt;
            end
            default: begin
                step_next = swmh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/swmh_datapath.sv
module swmh_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  swmh_pkg::uword_t                    uword,
    input  logic                                accept,
    input  logic [swmh_pkg::SAMPLE_W-1:0]       s_sample,
    output swmh_pkg::dp_stat_t                  stat,
    output logic [swmh_pkg::SAMPLE_W-1:0]       median,
    output logic [swmh_pkg::FILL_W-1:0]         held
);

    localparam int BW = swmh_pkg::BIN_W;
    localparam int FW = swmh_pkg::FILL_W;
    localparam int CW = swmh_pkg::CNT_W;
    localparam int SW = swmh_pkg::SLOT_W;

    // Memories
    logic [BW-1:0] ring_mem [swmh_pkg::WINDOW_LENGTH];
    logic [CW-1:0] cnt_mem  [swmh_pkg::NUM_BINS];

    logic [swmh_pkg::NUM_BINS-1:0] cnt_vld_reg;
    logic [CW-1:0] cnt_q_reg;
    logic          cnt_qv_reg;
    logic [BW-1:0] ring_q_reg;

    // Control registers
    logic [SW-1:0] slot_reg, slot_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          dv_reg, dv_next;

    // Payload registers
    logic [BW-1:0] sample_reg, sample_next;
    logic [BW-1:0] scan_reg, scan_next;
    logic [BW-1:0] bin_reg, bin_next;
    logic [FW-1:0] run_reg, run_next;
    logic [BW-1:0] lo_reg, lo_next;
    logic [BW-1:0] hi_reg, hi_next;

    logic [BW-1:0] sat_bin;
    logic [BW-1:0] rd_addr;
    logic [BW-1:0] wr_addr;
    logic [CW-1:0] wr_data;
    logic          cnt_we;
    logic [CW-1:0] cnt_rd;
    logic [FW:0]   want_wide;
    logic [FW-1:0] want;
    logic [FW:0]   run_sum;
    logic          lo_hit;
    logic          hi_hit;
    logic [BW:0]   mid_sum;

    always_comb begin
        sat_bin = ({1'b0, s_sample} >= swmh_pkg::BIN_LIMIT) ? swmh_pkg::LAST_BIN
                                                             : s_sample[BW-1:0];
        cnt_rd    = cnt_qv_reg ? cnt_q_reg : '0;
        want_wide = {1'b0, fill_reg} + {{FW{1'b0}}, 1'b1};
        want      = want_wide[FW:1];
        run_sum   = {1'b0, run_reg} + {1'b0, cnt_rd};
        lo_hit    = dv_reg && ((run_sum >= {1'b0, want}) || (bin_reg == swmh_pkg::LAST_BIN));
        hi_hit    = dv_reg && ((cnt_rd != '0) || (bin_reg == swmh_pkg::LAST_BIN));

        stat.full     = (fill_reg == swmh_pkg::WIN_FULL);
        stat.done     = uword.scan_lo ? lo_hit : hi_hit;
        stat.resolved = ((fill_reg >> 1) < want) || (run_reg > want)
                        || (lo_reg == swmh_pkg::LAST_BIN);

        unique case (uword.rd_src)
            swmh_pkg::RD_SAMPLE: rd_addr = sample_reg;
            swmh_pkg::RD_OLD:    rd_addr = ring_q_reg;
            swmh_pkg::RD_SCAN:   rd_addr = scan_reg;
            default:             rd_addr = scan_reg;
        endcase

        unique case (uword.wr_op)
            swmh_pkg::WR_INC: begin
                cnt_we  = 1'b1;
                wr_addr = sample_reg;
                wr_data = cnt_rd + {{(CW-1){1'b0}}, 1'b1};
            end
            swmh_pkg::WR_DEC: begin
                cnt_we  = (cnt_rd != '0);
                wr_addr = ring_q_reg;
                wr_data = cnt_rd - {{(CW-1){1'b0}}, 1'b1};
            end
            default: begin
                cnt_we  = 1'b0;
                wr_addr = sample_reg;
                wr_data = cnt_rd;
            end
        endcase

        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        median  = swmh_pkg::SAMPLE_W'(mid_sum[BW:1]);
        held    = fill_reg;
    end

    always_comb begin
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        dv_next     = dv_reg;
        sample_next = sample_reg;
        scan_next   = scan_reg;
        bin_next    = bin_reg;
        run_next    = run_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;

        if (accept) sample_next = sat_bin;

        // Store the sample, advance the slot, restart the scan at bin zero
        if (uword.ring_wr) begin
            slot_next = (slot_reg == swmh_pkg::LAST_SLOT) ? '0
                                                          : slot_reg + {{(SW-1){1'b0}}, 1'b1};
            fill_next = stat.full ? fill_reg : fill_reg + {{(FW-1){1'b0}}, 1'b1};
            scan_next = '0;
            dv_next   = 1'b0;
            run_next  = '0;
        end

        // Issue one bin read per cycle; data returns in the next cycle
        if (uword.scan_lo || uword.scan_hi) begin
            scan_next = scan_reg + {{(BW-1){1'b0}}, 1'b1};
            dv_next   = 1'b1;
            bin_next  = scan_reg;
        end

        if (uword.scan_lo && dv_reg) begin
            run_next = run_sum[FW-1:0];
            if (lo_hit) begin
                lo_next = bin_reg;
                hi_next = bin_reg;
            end
        end

        if (uword.scan_hi && dv_reg && (cnt_rd != '0)) hi_next = bin_reg;

        if (uword.decide && !stat.resolved) begin
            scan_next = lo_reg + {{(BW-1){1'b0}}, 1'b1};
            dv_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg    <= '0;
            fill_reg    <= '0;
            dv_reg      <= 1'b0;
            cnt_vld_reg <= '0;
            cnt_qv_reg  <= 1'b0;
        end else begin
            slot_reg   <= slot_next;
            fill_reg   <= fill_next;
            dv_reg     <= dv_next;
            cnt_qv_reg <= cnt_vld_reg[rd_addr];
            if (cnt_we) cnt_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        scan_reg   <= scan_next;
        bin_reg    <= bin_next;
        run_reg    <= run_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[wr_addr] <= wr_data;
        cnt_q_reg <= cnt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (uword.ring_wr) ring_mem[slot_reg] <= sample_reg;
        if (uword.ring_rd) ring_q_reg <= ring_mem[slot_reg];
    end

`ifndef SYNTH
    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= swmh_pkg::WIN_FULL)
        else $error("window count beyond window length");

    a_old_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (uword.wr_op == swmh_pkg::WR_DEC) |-> (cnt_rd != '0))
        else $error("evicted sample has an empty bin");
`endif

endmodule

// File: rtl/sliding_window_median_histogram.sv
// Sliding-window running median of 8-bit samples, kept as a value histogram.
//
// Input channel (s_valid/s_ready/s_sample): one request carries one sample.
// A sample at or above the bin count lands in the top bin. The newest
// WINDOW_LENGTH samples are kept in a ring memory; the histogram holds one
// count per bin.
// Output channel (m_valid/m_ready/m_median/m_samples_held): one result per
// request, the window median (floored mean of the middle pair for an even
// count) and the number of samples now in the window.
// Timing: a small control store steps the datapath. A request passes from
// the accepting idle step through reading and incrementing the new bin
// (plus reading and decrementing the evicted sample's bin once the window
// is full) to the ring write, then scans one bin per cycle up to the lower
// median bin, decides, scans on to the next filled bin when the middle pair
// splits, and emits; the histogram port does one read and one write per
// cycle, and a new request is taken only after the last one is emitted.
// Reset clears the window, the histogram (through per-bin valid bits) and
// the output register; no clearing pass is needed. A stalled receiver
// holds the result; the next request is still taken and processed, and
// the block waits at emit until the output register frees.
module sliding_window_median_histogram (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [swmh_pkg::SAMPLE_W-1:0]     s_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [swmh_pkg::SAMPLE_W-1:0]     m_median,
    output logic [swmh_pkg::HELD_W-1:0]       m_samples_held
);

    swmh_pkg::uword_t     uword;
    swmh_pkg::seq_flags_t seq_flags;
    swmh_pkg::dp_stat_t   dp_stat;

    logic                            accept;
    logic                            out_free;
    logic                            emit_fire;
    logic [swmh_pkg::SAMPLE_W-1:0]   dp_median;
    logic [swmh_pkg::FILL_W-1:0]     dp_held;

    logic                            m_valid_reg, m_valid_next;
    logic [swmh_pkg::SAMPLE_W-1:0]   m_median_reg;
    logic [swmh_pkg::HELD_W-1:0]     m_held_reg;

    // Take a request only in the idle step, never while reset is held
    assign s_ready   = uword.take && aresetn;
    assign accept    = s_valid && s_ready;
    // The output register is free once empty or being drained this cycle
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = uword.emit && out_free;

    assign seq_flags.accept   = accept;
    assign seq_flags.out_free = out_free;
    assign seq_flags.dp       = dp_stat;

    swmh_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (seq_flags),
        .uword   (uword)
    );

    swmh_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .uword    (uword),
        .accept   (accept),
        .s_sample (s_sample),
        .stat     (dp_stat),
        .median   (dp_median),
        .held     (dp_held)
    );

    // Hold the result until the receiver drains it; load on emit
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) m_valid_next = 1'b0;
        if (emit_fire) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_median_reg <= dp_median;
            m_held_reg   <= swmh_pkg::HELD_W'(dp_held);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median       = m_median_reg;
    assign m_samples_held = m_held_reg;

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> m_valid)
        else $error("emitted result not presented");
`endif

endmodule

// File: tb/swmh_median_checker.sv
module swmh_median_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [swmh_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [swmh_pkg::SAMPLE_W-1:0] m_median,
    input  logic [swmh_pkg::HELD_W-1:0]   m_samples_held,
    output int                            mismatch_count,
    output int                            results_pending,
    output int                            results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [swmh_pkg::SAMPLE_W-1:0] median;
        logic [swmh_pkg::HELD_W-1:0]   held;
    } window_result_t;

    // Shadow copy of the window and its histogram
    logic [swmh_pkg::BIN_W-1:0] window_bins [swmh_pkg::WINDOW_LENGTH];
    int unsigned      bin_count [swmh_pkg::NUM_BINS];
    int unsigned      next_slot;
    int unsigned      held_now;

    window_result_t   pending_medians [$];
    window_result_t   oldest;
    int               result_errs;

    function automatic logic [swmh_pkg::BIN_W-1:0] to_bin(
        input logic [swmh_pkg::SAMPLE_W-1:0] s);
        if (int'(s) >= swmh_pkg::NUM_BINS)
            return swmh_pkg::LAST_BIN;
        return swmh_pkg::BIN_W'(s);
    endfunction

    // Lower middle bin, then the next filled bin when the middle pair splits
    function automatic logic [swmh_pkg::SAMPLE_W-1:0] window_median();
        int unsigned want;
        int unsigned run;
        int unsigned lo;
        int unsigned hi;
        int          b;
        bit          found;
        want  = (held_now + 1) >> 1;
        run   = 0;
        lo    = swmh_pkg::NUM_BINS - 1;
        found = 1'b0;
        for (b = 0; b < swmh_pkg::NUM_BINS && !found; b++) begin
            run += bin_count[b];
            if (run >= want) begin
                lo    = b;
                found = 1'b1;
            end
        end
        if ((held_now >> 1) < want || run > want)
            return swmh_pkg::SAMPLE_W'(lo);
        hi    = lo;
        found = 1'b0;
        for (b = int'(lo) + 1; b < swmh_pkg::NUM_BINS && !found; b++) begin
            if (bin_count[b] != 0) begin
                hi    = b;
                found = 1'b1;
            end
        end
        return swmh_pkg::SAMPLE_W'((lo + hi) >> 1);
    endfunction

    task automatic take_sample(input logic [swmh_pkg::SAMPLE_W-1:0] s);
        logic [swmh_pkg::BIN_W-1:0] bin;
        logic [swmh_pkg::BIN_W-1:0] evicted;
        window_result_t   r;
        bin = to_bin(s);
        bin_count[bin]++;
        if (next_slot >= swmh_pkg::WINDOW_LENGTH)
            next_slot = 0;
        if (held_now >= swmh_pkg::WINDOW_LENGTH) begin
            // drop the oldest sample before it is overwritten
            evicted = window_bins[next_slot];
            if (bin_count[evicted] != 0)
                bin_count[evicted]--;
            held_now = swmh_pkg::WINDOW_LENGTH;
        end else begin
            held_now++;
        end
        window_bins[next_slot] = bin;
        next_slot = (next_slot + 1 >= swmh_pkg::WINDOW_LENGTH) ? 0 : next_slot + 1;
        r.median = window_median();
        r.held   = swmh_pkg::HELD_W'(held_now);
        pending_medians.push_back(r);
    endtask

    task automatic clear_window();
        int b;
        for (b = 0; b < swmh_pkg::NUM_BINS; b++)
            bin_count[b] = 0;
        next_slot = 0;
        held_now  = 0;
        pending_medians.delete();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_window();
            mismatch_count  <= 0;
            results_checked <= 0;
        end else begin
            result_errs = 0;
            // check results first: a request taken at this edge cannot answer here
            if (m_valid && m_ready) begin
                if (pending_medians.size() == 0) begin
                    $error("unexpected result: median %0d, samples_held %0d",
                           m_median, m_samples_held);
                    result_errs++;
                end else begin
                    oldest = pending_medians.pop_front();
                    results_checked <= results_checked + 1;
                    if (m_median !== oldest.median) begin
                        $error("median: expected %0d, actual %0d", oldest.median, m_median);
                        result_errs++;
                    end
                    if (m_samples_held !== oldest.held) begin
                        $error("samples_held: expected %0d, actual %0d",
                               oldest.held, m_samples_held);
                        result_errs++;
                    end
                end
            end
            if (result_errs != 0)
                mismatch_count <= mismatch_count + result_errs;
            if (s_valid && s_ready)
                take_sample(s_sample);
        end
        results_pending <= pending_medians.size();
    end

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch with no handshake on either side before the run is
    // declared hung. The slowest correct stretch is the receiver hold-off
    // below; a long sender gap plus a full bin scan is far shorter.
    localparam int HOLD_CYCLES  = 3000;
    localparam int STALL_LIMIT  = 20000;
    // Wait out the slowest request, a full bin scan, at the end.
    localparam int DRAIN_CYCLES = swmh_pkg::NUM_BINS + 50;
    localparam int RANDOM_ITEMS = 480;
    localparam int CORNERS      = 20;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [swmh_pkg::SAMPLE_W-1:0] s_sample;
    logic                          m_valid;
    logic                          m_ready;
    logic [swmh_pkg::SAMPLE_W-1:0] m_median;
    logic [swmh_pkg::HELD_W-1:0]   m_samples_held;

    int mismatches;
    int outstanding;
    int checked;

    int  sent;
    int  idle_cycles;
    bit  squeeze_req;   // ask the receiver for its one long hold-off

    logic [swmh_pkg::SAMPLE_W-1:0] corner_samples [0:CORNERS-1];

    sliding_window_median_histogram uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_median       (m_median),
        .m_samples_held (m_samples_held)
    );

    swmh_median_checker median_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_median        (m_median),
        .m_samples_held  (m_samples_held),
        .mismatch_count  (mismatches),
        .results_pending (outstanding),
        .results_checked (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly back-to-back requests, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // Uniform values, with extra weight on the extremes and on a tight
    // cluster so that repeated middle values and split pairs both turn up.
    function automatic logic [swmh_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return swmh_pkg::SAMPLE_W'(8'h40 + $urandom_range(0, 3));
            default: return swmh_pkg::SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one request after an optional gap and hold it until it is taken.
    // Call right after a rising edge; returns right after the accepting edge.
    task automatic push_sample(input logic [swmh_pkg::SAMPLE_W-1:0] value, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    // Stimulus and verdict
    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_sample    <= '0;
        sent        = 0;
        squeeze_req = 1'b0;
        // Extremes, alternating bit patterns, a far split pair (0 and 255),
        // repeated middle values, and near neighbors.
        corner_samples = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h80, 8'h01, 8'hFE,
                           8'h7F, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h07, 8'h07,
                           8'hC8, 8'hC8, 8'h03, 8'hFA};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_samples[i])
            push_sample(corner_samples[i], pick_gap());

        // Random requests with idling; partway in, have the receiver stall
        // long enough that the block fills and backs up the input.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100)
                squeeze_req = 1'b1;
            push_sample(random_sample(), (i >= 100 && i < 110) ? 0 : pick_gap());
        end
        s_valid <= 1'b0;

        // Drain: let the last prediction land, wait for every result, then
        // for any stray one.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d samples sent and %0d medians checked with random idling",
                 sent, checked);
        $display("Summary: one %0d-cycle receiver stall taken with the input backed up",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("sliding_window_median_histogram: match");
        else
            $display("sliding_window_median_histogram: mismatch");
        $finish;
    end

    // Receiver: random bursts of ready and stall, one long hold-off on request
    initial begin
        bit squeezed;
        int r;
        int n;
        squeezed = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (squeeze_req && !squeezed) begin
                // hold off the results while the sender keeps offering
                squeezed = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    m_ready <= 1'b1;
                    n = $urandom_range(1, 30);
                end else if (r < 92) begin
                    m_ready <= 1'b0;
                    n = $urandom_range(1, 4);
                end else begin
                    m_ready <= 1'b0;
                    n = $urandom_range(20, 150);
                end
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Watchdog: count cycles with no request or result moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("sliding_window_median_histogram: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule

// File: sliding_window_median_histogram.f
rtl/swmh_pkg.sv
rtl/swmh_seq.sv
rtl/swmh_datapath.sv
rtl/sliding_window_median_histogram.sv
tb/swmh_median_checker.sv
tb/tb.sv
